// ===== rtl/nectx_pkg.sv =====
// Shared types and constants for the NEC infrared frame transmitter.
package nectx_pkg;

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_START = 1'b1;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [5:0] CLOSING_BIT = 6'd32;

    localparam logic [5:0] RST_CARRIER_PERIOD = 6'd26;
    localparam logic [5:0] RST_CARRIER_LOW    = 6'd9;
    localparam logic [8:0] RST_LEADER_MARK    = 9'd346;
    localparam logic [8:0] RST_LEADER_SPACE   = 9'd173;
    localparam logic [7:0] RST_BIT_MARK       = 8'd21;
    localparam logic [7:0] RST_ONE_SPACE      = 8'd65;
    localparam logic [7:0] RST_ZERO_SPACE     = 8'd21;

    typedef struct packed {
        logic       opcode;
        logic [7:0] address_byte;
        logic [7:0] command_byte;
    } t_in_item;

    typedef struct packed {
        logic emitter_level;
        logic busy_res;
        logic frame_done;
        logic start_ignored;
    } t_out_item;

    typedef struct packed {
        logic [5:0] carrier_period_ticks;
        logic [5:0] carrier_low_ticks;
        logic [8:0] leader_mark_periods;
        logic [8:0] leader_space_periods;
        logic [7:0] bit_mark_periods;
        logic [7:0] one_space_periods;
        logic [7:0] zero_space_periods;
    } t_cfg;

endpackage

// ===== rtl/nec_ir_frame_transmitter_top.sv =====
// Latency: the result beat of an accepted item is presented on the next cycle.
// Throughput: one item per cycle; the counter and phase update is a single pass.
// A result beat held by downstream stalls the input only while it is unread.
// Reset clears the frame state to idle and loads the register defaults.
// No memory needs clearing, so items are accepted right after reset.
module nec_ir_frame_transmitter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  nectx_pkg::t_in_item                i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output nectx_pkg::t_out_item               o_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nectx_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nectx_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nectx_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import nectx_pkg::*;

    t_cfg cfg;

    nectx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nectx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef ASSERT_OFF
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted beat produced no result");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_done) |-> !o_data.busy_res)
        else $error("frame end while still busy");

    a_ignored_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.start_ignored) |-> o_data.busy_res)
        else $error("start dropped while idle");

    a_idle_pin_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.busy_res) |-> o_data.emitter_level)
        else $error("emitter driven while idle");
`endif

endmodule

// ===== rtl/nectx_regs.sv =====
// APB configuration register file for the NEC transmitter.
module nectx_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nectx_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nectx_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nectx_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output nectx_pkg::t_cfg                    o_cfg
);
    import nectx_pkg::*;

    typedef enum logic [2:0] {
        REG_CARRIER_PERIOD = 3'd0,
        REG_CARRIER_LOW    = 3'd1,
        REG_LEADER_MARK    = 3'd2,
        REG_LEADER_SPACE   = 3'd3,
        REG_BIT_MARK       = 3'd4,
        REG_ONE_SPACE      = 3'd5,
        REG_ZERO_SPACE     = 3'd6
    } t_reg_idx;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_period_ticks <= RST_CARRIER_PERIOD;
            r_cfg.carrier_low_ticks    <= RST_CARRIER_LOW;
            r_cfg.leader_mark_periods  <= RST_LEADER_MARK;
            r_cfg.leader_space_periods <= RST_LEADER_SPACE;
            r_cfg.bit_mark_periods     <= RST_BIT_MARK;
            r_cfg.one_space_periods    <= RST_ONE_SPACE;
            r_cfg.zero_space_periods   <= RST_ZERO_SPACE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CARRIER_PERIOD: r_cfg.carrier_period_ticks <= pwdata[5:0];
                REG_CARRIER_LOW:    r_cfg.carrier_low_ticks    <= pwdata[5:0];
                REG_LEADER_MARK:    r_cfg.leader_mark_periods  <= pwdata[8:0];
                REG_LEADER_SPACE:   r_cfg.leader_space_periods <= pwdata[8:0];
                REG_BIT_MARK:       r_cfg.bit_mark_periods     <= pwdata[7:0];
                REG_ONE_SPACE:      r_cfg.one_space_periods    <= pwdata[7:0];
                REG_ZERO_SPACE:     r_cfg.zero_space_periods   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CARRIER_PERIOD: prdata = {26'd0, r_cfg.carrier_period_ticks};
            REG_CARRIER_LOW:    prdata = {26'd0, r_cfg.carrier_low_ticks};
            REG_LEADER_MARK:    prdata = {23'd0, r_cfg.leader_mark_periods};
            REG_LEADER_SPACE:   prdata = {23'd0, r_cfg.leader_space_periods};
            REG_BIT_MARK:       prdata = {24'd0, r_cfg.bit_mark_periods};
            REG_ONE_SPACE:      prdata = {24'd0, r_cfg.one_space_periods};
            REG_ZERO_SPACE:     prdata = {24'd0, r_cfg.zero_space_periods};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/nectx_core.sv =====
// Frame sequencer: timing counters, frame state and registered result beat.
module nectx_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nectx_pkg::t_cfg       i_cfg,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  nectx_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output nectx_pkg::t_out_item  o_data
);
    import nectx_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [5:0] r_bit_pos, n_bit_pos;
    logic [8:0] r_period_cnt, n_period_cnt;
    logic [5:0] r_sub_tick, n_sub_tick;
    logic [31:0] r_frame_word, n_frame_word;
    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic       accept;
    logic       cur_bit;
    logic [5:0] period_lim;
    logic [8:0] seg_raw;
    logic [8:0] seg_lim;
    logic [5:0] sub_inc;
    logic [8:0] period_inc;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign cur_bit    = (r_bit_pos >= CLOSING_BIT) ? 1'b0 : r_frame_word[r_bit_pos[4:0]];
    assign period_lim = (i_cfg.carrier_period_ticks == 6'd0) ? 6'd1
                                                             : i_cfg.carrier_period_ticks;
    assign seg_lim    = (seg_raw == 9'd0) ? 9'd1 : seg_raw;
    assign sub_inc    = r_sub_tick + 6'd1;
    assign period_inc = r_period_cnt + 9'd1;

    always_comb begin
        unique case (r_phase)
            PH_LEAD_MARK:  seg_raw = i_cfg.leader_mark_periods;
            PH_LEAD_SPACE: seg_raw = i_cfg.leader_space_periods;
            PH_BIT_MARK:   seg_raw = {1'b0, i_cfg.bit_mark_periods};
            PH_BIT_SPACE:  seg_raw = cur_bit ? {1'b0, i_cfg.one_space_periods}
                                             : {1'b0, i_cfg.zero_space_periods};
            default:       seg_raw = 9'd1;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_bit_pos     = r_bit_pos;
        n_period_cnt  = r_period_cnt;
        n_sub_tick    = r_sub_tick;
        n_frame_word  = r_frame_word;
        n_out         = '0;

        if (i_data.opcode == OP_START) begin
            if (r_phase != PH_IDLE) begin
                n_out.start_ignored = 1'b1;
            end else begin
                n_frame_word = {~i_data.command_byte, i_data.command_byte,
                                ~i_data.address_byte, i_data.address_byte};
                n_phase      = PH_LEAD_MARK;
                n_bit_pos    = '0;
                n_period_cnt = '0;
                n_sub_tick   = '0;
            end
        end else if (r_phase != PH_IDLE) begin
            if (sub_inc < period_lim) begin
                n_sub_tick = sub_inc;
            end else begin
                n_sub_tick = '0;
                if (period_inc < seg_lim) begin
                    n_period_cnt = period_inc;
                end else begin
                    n_period_cnt = '0;
                    unique case (r_phase)
                        PH_LEAD_MARK: begin
                            n_phase = PH_LEAD_SPACE;
                        end
                        PH_LEAD_SPACE: begin
                            n_phase   = PH_BIT_MARK;
                            n_bit_pos = '0;
                        end
                        PH_BIT_MARK: begin
                            n_phase = PH_BIT_SPACE;
                        end
                        PH_BIT_SPACE: begin
                            if (r_bit_pos >= CLOSING_BIT) begin
                                n_phase            = PH_IDLE;
                                n_bit_pos          = '0;
                                n_out.frame_done   = 1'b1;
                            end else begin
                                n_bit_pos = r_bit_pos + 6'd1;
                                n_phase   = PH_BIT_MARK;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        n_out.busy_res      = (n_phase != PH_IDLE);
        n_out.emitter_level = !(((n_phase == PH_LEAD_MARK) || (n_phase == PH_BIT_MARK))
                                && (n_sub_tick < i_cfg.carrier_low_ticks));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_pos    <= '0;
            r_period_cnt <= '0;
            r_sub_tick   <= '0;
            r_frame_word <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_bit_pos    <= n_bit_pos;
                r_period_cnt <= n_period_cnt;
                r_sub_tick   <= n_sub_tick;
                r_frame_word <= n_frame_word;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== bench/tb_nec_ir_frame_transmitter_top.sv =====
// Self-checking bench for the NEC IR transmitter: directed frames, random beats, mid-frame writes.
module tb_nec_ir_frame_transmitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nectx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE
    } t_tx_phase;

    typedef enum int unsigned {
        REG_CARRIER_PERIOD,
        REG_CARRIER_LOW,
        REG_LEADER_MARK,
        REG_LEADER_SPACE,
        REG_BIT_MARK,
        REG_ONE_SPACE,
        REG_ZERO_SPACE
    } t_reg_index;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_item              i_data  = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_tx_phase   tx_phase;
    logic [5:0]  tx_bit;
    logic [8:0]  tx_periods;
    logic [5:0]  tx_sub;
    logic [31:0] tx_word;
    t_cfg        tx_cfg;

    t_out_item   expected_pin_states[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_hold     = 0;
    int unsigned stall_style    = 0;

    nec_ir_frame_transmitter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10ns i_clk = ~i_clk;

    function automatic logic [8:0] min_one(input logic [8:0] v);
        return (v == 9'd0) ? 9'd1 : v;
    endfunction

    function automatic logic [8:0] segment_limit(input t_tx_phase ph);
        logic       bit_val;
        logic [8:0] lim;
        bit_val = (tx_bit < CLOSING_BIT) ? tx_word[tx_bit[4:0]] : 1'b0;
        lim = 9'd1;
        unique case (ph)
            PH_LEAD_MARK:  lim = tx_cfg.leader_mark_periods;
            PH_LEAD_SPACE: lim = tx_cfg.leader_space_periods;
            PH_BIT_MARK:   lim = {1'b0, tx_cfg.bit_mark_periods};
            PH_BIT_SPACE: begin
                if (bit_val)
                    lim = {1'b0, tx_cfg.one_space_periods};
                else
                    lim = {1'b0, tx_cfg.zero_space_periods};
            end
            default:       lim = 9'd1;
        endcase
        return lim;
    endfunction

    function automatic logic advance_carrier_tick();
        if (tx_phase == PH_IDLE)
            return 1'b0;
        tx_sub = tx_sub + 6'd1;
        if ({3'b000, tx_sub} < min_one({3'b000, tx_cfg.carrier_period_ticks}))
            return 1'b0;
        tx_sub = '0;
        tx_periods = tx_periods + 9'd1;
        if (tx_periods < min_one(segment_limit(tx_phase)))
            return 1'b0;
        tx_periods = '0;
        unique case (tx_phase)
            PH_LEAD_MARK:  tx_phase = PH_LEAD_SPACE;
            PH_LEAD_SPACE: begin
                tx_phase = PH_BIT_MARK;
                tx_bit = '0;
            end
            PH_BIT_MARK:   tx_phase = PH_BIT_SPACE;
            PH_BIT_SPACE: begin
                if (tx_bit >= CLOSING_BIT) begin
                    tx_phase = PH_IDLE;
                    tx_bit = '0;
                    return 1'b1;
                end
                tx_bit = tx_bit + 6'd1;
                tx_phase = PH_BIT_MARK;
            end
            default:       tx_phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic t_out_item advance_emitter(input t_in_item item);
        t_out_item r;
        logic      done;
        logic      ignored;
        done = 1'b0;
        ignored = 1'b0;
        if (item.opcode == OP_START) begin
            if (tx_phase != PH_IDLE) begin
                ignored = 1'b1;
            end else begin
                tx_word = {~item.command_byte, item.command_byte,
                           ~item.address_byte, item.address_byte};
                tx_phase = PH_LEAD_MARK;
                tx_bit = '0;
                tx_periods = '0;
                tx_sub = '0;
            end
        end else begin
            done = advance_carrier_tick();
        end
        if (tx_phase == PH_LEAD_MARK || tx_phase == PH_BIT_MARK)
            r.emitter_level = (tx_sub < tx_cfg.carrier_low_ticks) ? 1'b0 : 1'b1;
        else
            r.emitter_level = 1'b1;
        r.busy_res = (tx_phase != PH_IDLE);
        r.frame_done = done;
        r.start_ignored = ignored;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] addr, input logic [7:0] cmd);
        t_in_item    item;
        int unsigned gap_len;
        item.opcode = op;
        item.address_byte = addr;
        item.command_byte = cmd;
        i_data <= item;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        expected_pin_states.push_back(advance_emitter(item));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap_len != 0) begin
                i_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        if (i_valid)
            i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pin_states.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx << 2);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        unique case (idx)
            REG_CARRIER_PERIOD: tx_cfg.carrier_period_ticks = value[5:0];
            REG_CARRIER_LOW:    tx_cfg.carrier_low_ticks = value[5:0];
            REG_LEADER_MARK:    tx_cfg.leader_mark_periods = value[8:0];
            REG_LEADER_SPACE:   tx_cfg.leader_space_periods = value[8:0];
            REG_BIT_MARK:       tx_cfg.bit_mark_periods = value[7:0];
            REG_ONE_SPACE:      tx_cfg.one_space_periods = value[7:0];
            default:            tx_cfg.zero_space_periods = value[7:0];
        endcase
    endtask

    task automatic load_settings(input int unsigned period, input int unsigned low,
                                 input int unsigned lead_mark, input int unsigned lead_space,
                                 input int unsigned bit_mark, input int unsigned one_space,
                                 input int unsigned zero_space);
        drain_results();
        write_reg(REG_CARRIER_PERIOD, period);
        write_reg(REG_CARRIER_LOW, low);
        write_reg(REG_LEADER_MARK, lead_mark);
        write_reg(REG_LEADER_SPACE, lead_space);
        write_reg(REG_BIT_MARK, bit_mark);
        write_reg(REG_ONE_SPACE, one_space);
        write_reg(REG_ZERO_SPACE, zero_space);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        logic op;
        repeat (count) begin
            if (tx_phase == PH_IDLE)
                op = ($urandom_range(0, 2) != 0) ? OP_START : OP_TICK;
            else
                op = ($urandom_range(0, 15) == 0) ? OP_START : OP_TICK;
            send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_idle_ticks();
        send_item(OP_TICK, 8'hFF, 8'h00);
        send_item(OP_TICK, 8'h00, 8'hFF);
    endtask

    task automatic test_default_leader();
        send_item(OP_START, 8'h00, 8'hFF);
        repeat (10) send_tick();
        send_item(OP_START, 8'hFF, 8'h00);
        repeat (2) send_tick();
    endtask

    task automatic test_write_mid_frame();
        load_settings(3, 1, 2, 1, 1, 2, 1);
        repeat (6) send_tick();
    endtask

    task automatic test_zero_settings();
        load_settings(0, 0, 0, 0, 0, 0, 0);
        run_random(140);
    endtask

    task automatic test_unit_period();
        load_settings(1, 1, 1, 1, 1, 1, 1);
        while (tx_phase != PH_IDLE) send_tick();
        send_item(OP_START, 8'hFF, 8'h00);
        run_random(120);
    endtask

    task automatic test_register_maxima();
        load_settings(63, 62, 511, 511, 255, 255, 255);
        run_random(90);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            load_settings($urandom_range(0, 2), $urandom_range(0, 4), $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 3),
                          $urandom_range(0, 2));
            run_random(75);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(16, 96);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        unique case (stall_style)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= (cycle_count[1:0] == 2'b11);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_pin_states.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatch_count++;
            end else begin
                want = expected_pin_states.pop_front();
                if (o_data.emitter_level !== want.emitter_level) begin
                    $error("emitter_level: expected %0b, got %0b",
                           want.emitter_level, o_data.emitter_level);
                    mismatch_count++;
                end
                if (o_data.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, o_data.busy_res);
                    mismatch_count++;
                end
                if (o_data.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b",
                           want.frame_done, o_data.frame_done);
                    mismatch_count++;
                end
                if (o_data.start_ignored !== want.start_ignored) begin
                    $error("start_ignored: expected %0b, got %0b",
                           want.start_ignored, o_data.start_ignored);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        tx_cfg.carrier_period_ticks = RST_CARRIER_PERIOD;
        tx_cfg.carrier_low_ticks = RST_CARRIER_LOW;
        tx_cfg.leader_mark_periods = RST_LEADER_MARK;
        tx_cfg.leader_space_periods = RST_LEADER_SPACE;
        tx_cfg.bit_mark_periods = RST_BIT_MARK;
        tx_cfg.one_space_periods = RST_ONE_SPACE;
        tx_cfg.zero_space_periods = RST_ZERO_SPACE;
        tx_phase = PH_IDLE;
        tx_bit = '0;
        tx_periods = '0;
        tx_sub = '0;
        tx_word = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_default_leader();
        test_write_mid_frame();
        test_zero_settings();
        test_unit_period();
        test_register_maxima();
        test_random_settings();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nectx_pkg.sv
rtl/nectx_regs.sv
rtl/nectx_core.sv
rtl/nec_ir_frame_transmitter_top.sv
bench/tb_nec_ir_frame_transmitter_top.sv
